// File: rtl/variable_record_ring_queue_defines.svh
// Assertion macros used by the ring queue top module.
`ifndef VARIABLE_RECORD_RING_QUEUE_DEFINES_SVH
`define VARIABLE_RECORD_RING_QUEUE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define VRRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define VRRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vrrq_pkg.sv
// Types, constants and codes of the variable record ring queue.
`default_nettype none

package vrrq_pkg;

  // Ring geometry
  localparam int BUF_BYTES  = 4096;
  localparam int HDR_BYTES  = 4;
  localparam int MAX_PACKET = 1500;

  // Widths
  localparam int ADDR_W = $clog2(BUF_BYTES);   // byte address in the ring
  localparam int PTR_W  = ADDR_W + 1;          // pointer, end of ring included
  localparam int LEN_W  = 11;                  // lengths, counts and totals
  localparam int CFG_W  = 13;                  // ring_size register

  // Operation codes
  localparam logic [1:0] OP_WRITE_BEGIN = 2'd0;
  localparam logic [1:0] OP_WRITE_BYTE  = 2'd1;
  localparam logic [1:0] OP_READ_BEGIN  = 2'd2;
  localparam logic [1:0] OP_READ_BYTE   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_OOS     = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       data_out;
    logic             last;
    logic [LEN_W-1:0] count;
    logic             empty_res;
    logic             full_res;
  } result_t;

  // Space check outcome for a write request
  typedef struct packed {
    logic              room;
    logic [ADDR_W-1:0] start;
  } alloc_t;

  // Header entry of a linked record
  typedef struct packed {
    logic [LEN_W-1:0]  total;
    logic [ADDR_W-1:0] link;
  } hdr_t;

endpackage

`default_nettype wire

// File: rtl/vrrq_alloc.sv
// Space check that places a new record at the write pointer or the ring start.
`default_nettype none

module vrrq_alloc (
  input  logic [vrrq_pkg::PTR_W-1:0] wp,
  input  logic [vrrq_pkg::PTR_W-1:0] rp,
  input  logic [vrrq_pkg::PTR_W-1:0] size,
  input  logic [vrrq_pkg::LEN_W-1:0] length,
  input  logic                       full,
  output vrrq_pkg::alloc_t           alloc
);
  import vrrq_pkg::*;

  logic [PTR_W-1:0] need;

  // Header plus payload
  assign need = PTR_W'(HDR_BYTES) + PTR_W'(length);

  // Take the tail, else wrap to the start ahead of the read pointer
  always_comb begin
    alloc.room  = 1'b0;
    alloc.start = wp[ADDR_W-1:0];
    if (!full && (length <= LEN_W'(MAX_PACKET))) begin
      if (wp >= rp) begin
        if ((wp <= size) && ((size - wp) >= need)) begin
          alloc.room = 1'b1;
        end else if (rp >= need) begin
          alloc.room  = 1'b1;
          alloc.start = '0;
        end
      end else if ((rp - wp) >= need) begin
        alloc.room = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/variable_record_ring_queue.sv
// Sequence: an accepted request is registered together with the memory read data,
// then the update state reads the registered data, writes back and registers the
// result. A new request is taken only after the last one has finished.
// A stalled result holds the update state until it is taken.
// Reset: pointers, flags and open operations clear, ring_size returns to 4096;
// ring and header memories are not cleared and need no clearing pass.
`default_nettype none
`include "variable_record_ring_queue_defines.svh"

module variable_record_ring_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  vrrq_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output vrrq_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vrrq_pkg::CFG_W-1:0] cfg_data
);
  import vrrq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // Control and pointer state
  logic              state;
  logic [CFG_W-1:0]  ring_size;
  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic              full_flag, full_next;
  logic              has_records, has_records_next;
  logic [ADDR_W-1:0] newest_record, newest_record_next;
  logic [LEN_W-1:0]  newest_total, newest_total_next;
  logic [LEN_W-1:0]  write_left, write_left_next;
  logic [PTR_W-1:0]  write_address, write_address_next;
  logic [ADDR_W-1:0] write_start, write_start_next;
  logic [LEN_W-1:0]  write_total, write_total_next;
  logic [LEN_W-1:0]  read_left, read_left_next;
  logic [PTR_W-1:0]  read_address, read_address_next;
  item_t             item_q;
  result_t           result_next;

  // Memories
  logic [7:0]        ring_mem [BUF_BYTES];
  hdr_t              hdr_mem  [BUF_BYTES];
  logic [7:0]        ring_rdata;
  hdr_t              hdr_rdata;
  logic              ring_we;
  logic [ADDR_W-1:0] ring_waddr;
  logic              hdr_we;
  hdr_t              hdr_wdata;

  // Datapath helpers
  logic              accept;
  logic              done;
  logic [PTR_W-1:0]  size;
  alloc_t            alloc;
  logic              rec_newest;
  logic [LEN_W-1:0]  rec_total;
  logic [LEN_W-1:0]  payload;
  logic [LEN_W-1:0]  grant;
  logic              do_commit;
  logic [ADDR_W-1:0] commit_start;
  logic [LEN_W-1:0]  commit_total;
  logic              do_advance;

  // Hold requests while a ring size write is offered; take it only when idle
  assign item_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign done       = (state == S_EXEC) && (!result_valid || result_ready);

  // Clamp the ring size to the physical ring
  assign size = (ring_size > CFG_W'(BUF_BYTES)) ? PTR_W'(BUF_BYTES) : PTR_W'(ring_size);

  vrrq_alloc u_alloc (
    .wp     (wp),
    .rp     (rp),
    .size   (size),
    .length (item_q.length),
    .full   (full_flag),
    .alloc  (alloc)
  );

  // The newest record keeps its header in registers until the next one links it
  assign rec_newest = (rp[ADDR_W-1:0] == newest_record);
  assign rec_total  = rec_newest ? newest_total : hdr_rdata.total;
  assign payload    = (rec_total >= LEN_W'(HDR_BYTES)) ? (rec_total - LEN_W'(HDR_BYTES)) : '0;
  assign grant      = (item_q.length < payload) ? item_q.length : payload;

  // Execute the held request against the registered memory data
  always_comb begin
    wp_next            = wp;
    rp_next            = rp;
    full_next          = full_flag;
    has_records_next   = has_records;
    newest_record_next = newest_record;
    newest_total_next  = newest_total;
    write_left_next    = write_left;
    write_address_next = write_address;
    write_start_next   = write_start;
    write_total_next   = write_total;
    read_left_next     = read_left;
    read_address_next  = read_address;
    ring_we            = 1'b0;
    ring_waddr         = write_address[ADDR_W-1:0];
    hdr_we             = 1'b0;
    hdr_wdata.total    = newest_total;
    hdr_wdata.link     = '0;
    do_commit          = 1'b0;
    commit_start       = write_start;
    commit_total       = write_total;
    do_advance         = 1'b0;
    result_next        = '0;
    result_next.status = ST_OK;

    case (item_q.op)
      OP_WRITE_BEGIN: begin
        write_left_next = '0;
        if (alloc.room) begin
          result_next.count  = item_q.length;
          write_start_next   = alloc.start;
          write_address_next = PTR_W'(alloc.start) + PTR_W'(HDR_BYTES);
          write_left_next    = item_q.length;
          write_total_next   = LEN_W'(HDR_BYTES) + item_q.length;
          if (item_q.length == '0) begin
            do_commit    = 1'b1;
            commit_start = alloc.start;
            commit_total = LEN_W'(HDR_BYTES);
          end
        end else begin
          result_next.status = ST_NO_ROOM;
        end
      end
      OP_WRITE_BYTE: begin
        if (write_left == '0) begin
          result_next.status = ST_OOS;
        end else begin
          ring_we            = 1'b1;
          write_address_next = write_address + PTR_W'(1);
          write_left_next    = write_left - LEN_W'(1);
          if (write_left == LEN_W'(1)) begin
            do_commit = 1'b1;
          end
        end
      end
      OP_READ_BEGIN: begin
        if (!has_records || (rp >= PTR_W'(BUF_BYTES))) begin
          result_next.status = ST_EMPTY;
          read_left_next     = '0;
        end else begin
          result_next.count = grant;
          read_address_next = rp + PTR_W'(HDR_BYTES);
          read_left_next    = grant;
          if (grant == '0) begin
            do_advance = 1'b1;
          end
        end
      end
      OP_READ_BYTE: begin
        if (read_left == '0) begin
          result_next.status = ST_OOS;
        end else begin
          result_next.data_out = ring_rdata;
          read_address_next    = read_address + PTR_W'(1);
          read_left_next       = read_left - LEN_W'(1);
          if (read_left == LEN_W'(1)) begin
            result_next.last = 1'b1;
            do_advance       = 1'b1;
          end
        end
      end
      default: begin
        result_next.status = ST_OOS;
      end
    endcase

    // Link the finished record behind the newest one, or make it the first when none is queued
    if (do_commit) begin
      wp_next = PTR_W'(commit_start) + PTR_W'(commit_total);
      if (has_records) begin
        hdr_we         = 1'b1;
        hdr_wdata.link = commit_start;
        if (rp == wp_next) begin
          full_next = 1'b1;
        end
      end else begin
        rp_next          = PTR_W'(commit_start);
        has_records_next = 1'b1;
      end
      newest_record_next = commit_start;
      newest_total_next  = commit_total;
    end

    // Follow the link past the record just read, or empty the queue after the newest one
    if (do_advance) begin
      if (rp < PTR_W'(BUF_BYTES)) begin
        if (!rec_newest) begin
          rp_next = PTR_W'(hdr_rdata.link);
        end else begin
          rp_next          = rp + PTR_W'(rec_total);
          has_records_next = 1'b0;
        end
      end else begin
        has_records_next = 1'b0;
      end
      full_next      = 1'b0;
      read_left_next = '0;
    end

    result_next.empty_res = !has_records_next;
    result_next.full_res  = full_next;
  end

  // Sequence, pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_size     <= CFG_W'(BUF_BYTES);
      wp            <= '0;
      rp            <= '0;
      full_flag     <= 1'b0;
      has_records   <= 1'b0;
      newest_record <= '0;
      newest_total  <= '0;
      write_left    <= '0;
      write_address <= '0;
      write_start   <= '0;
      write_total   <= '0;
      read_left     <= '0;
      read_address  <= '0;
      result_valid  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      // New ring size: drop all records and open operations
      ring_size     <= cfg_data;
      wp            <= '0;
      rp            <= '0;
      full_flag     <= 1'b0;
      has_records   <= 1'b0;
      newest_record <= '0;
      write_left    <= '0;
      write_address <= '0;
      write_start   <= '0;
      read_left     <= '0;
      read_address  <= '0;
      if (result_ready) begin
        result_valid <= 1'b0;
      end
    end else begin
      if (accept) begin
        state  <= S_EXEC;
        item_q <= item;
      end
      if (done) begin
        state         <= S_IDLE;
        wp            <= wp_next;
        rp            <= rp_next;
        full_flag     <= full_next;
        has_records   <= has_records_next;
        newest_record <= newest_record_next;
        newest_total  <= newest_total_next;
        write_left    <= write_left_next;
        write_address <= write_address_next;
        write_start   <= write_start_next;
        write_total   <= write_total_next;
        read_left     <= read_left_next;
        read_address  <= read_address_next;
        result_valid  <= 1'b1;
        result        <= result_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload byte ring: read on accept, write on update
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rdata <= ring_mem[read_address[ADDR_W-1:0]];
    end
    if (done && ring_we) begin
      ring_mem[ring_waddr] <= item_q.data_byte;
    end
  end

  // Header table of linked records: read on accept, write on update
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_rdata <= hdr_mem[rp[ADDR_W-1:0]];
    end
    if (done && hdr_we) begin
      hdr_mem[newest_record] <= hdr_wdata;
    end
  end

  `VRRQ_ASSERT_IMP(a_full_meets, full_flag, has_records && (wp == rp), "full without pointers meeting")
  `VRRQ_ASSERT_IMP(a_read_open, read_left != '0, has_records, "read open with no records queued")
  `VRRQ_ASSERT_NXT(a_accept_exec, accept && !cfg_valid, state == S_EXEC, "accepted request not executed")
  `VRRQ_ASSERT_NXT(a_done_result, done && !cfg_valid, result_valid, "finished request gave no result")

endmodule

`default_nettype wire
